/* rtl/rgb_to_hsv_convert_assert.svh */
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Shared property templates for the converter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERT_ASSERT_SVH
`define RGB_TO_HSV_CONVERT_ASSERT_SVH

// Checks that a condition implies a consequence at the same clock edge.
`define RHC_ASSERT_IMPLY(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("RHC implication check failed");

// Checks that a condition implies a consequence at the next clock edge.
`define RHC_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("RHC next-cycle check failed");

`endif

/* rtl/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Field widths and the quotient bundle carried along the divider row.
// ----------------------------------------------------------------------------
package rhc_pkg;
    localparam int FRAC_BITS = 16;
    localparam int HUE_W     = 16;
    localparam int SAT_W     = 17;
    localparam int VAL_W     = 16;

    typedef struct packed {
        logic [SAT_W-1:0] sat;
        logic [HUE_W-1:0] hue;
    } t_quot;
endpackage

/* rtl/rhc_pix_if.sv */
// ----------------------------------------------------------------------------
// RGB pixel stream interface
// Valid/ready channel carrying one RGB pixel per transfer.
// ----------------------------------------------------------------------------
interface rhc_pix_if #(
    parameter int CB = 16
);
    logic          valid;
    logic          ready;
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

/* rtl/rhc_hsv_if.sv */
// ----------------------------------------------------------------------------
// HSV result stream interface
// Valid/ready channel carrying one HSV result per transfer.
// ----------------------------------------------------------------------------
interface rhc_hsv_if
    import rhc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue_turns;
    logic [SAT_W-1:0] sat_level;
    logic [VAL_W-1:0] val_level;

    modport source (output valid, hue_turns, sat_level, val_level, input ready);
    modport sink   (input valid, hue_turns, sat_level, val_level, output ready);
endinterface

/* rtl/rhc_cell.sv */
// ----------------------------------------------------------------------------
// RGB to HSV divider cell
// One restoring-division step for saturation and hue, registered.
// ----------------------------------------------------------------------------
module rhc_cell
    import rhc_pkg::*;
#(
    parameter int W = 19
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [W-1:0]     i_rem_s,
    input  logic [W-1:0]     i_den_s,
    input  logic [W-1:0]     i_rem_h,
    input  logic [W-1:0]     i_den_h,
    input  t_quot            i_quot,
    input  logic [VAL_W-1:0] i_val,
    output logic             o_valid,
    output logic [W-1:0]     o_rem_s,
    output logic [W-1:0]     o_den_s,
    output logic [W-1:0]     o_rem_h,
    output logic [W-1:0]     o_den_h,
    output t_quot            o_quot,
    output logic [VAL_W-1:0] o_val
);
    logic             r_valid;
    logic [W-1:0]     r_rem_s, r_den_s, r_rem_h, r_den_h;
    t_quot            r_quot;
    logic [VAL_W-1:0] r_val;

    logic [W:0]   ts, th;
    logic         ge_s, ge_h;
    logic [W-1:0] n_rem_s, n_rem_h;
    t_quot        n_quot;

    always_comb begin
        ts      = {i_rem_s, 1'b0};
        th      = {i_rem_h, 1'b0};
        ge_s    = ts >= {1'b0, i_den_s};
        ge_h    = th >= {1'b0, i_den_h};
        n_rem_s = ge_s ? W'(ts - {1'b0, i_den_s}) : W'(ts);
        n_rem_h = ge_h ? W'(th - {1'b0, i_den_h}) : W'(th);
        n_quot.sat = {i_quot.sat[SAT_W-2:0], ge_s};
        n_quot.hue = {i_quot.hue[HUE_W-2:0], ge_h};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_s <= n_rem_s;
            r_den_s <= i_den_s;
            r_rem_h <= n_rem_h;
            r_den_h <= i_den_h;
            r_quot  <= n_quot;
            r_val   <= i_val;
        end
    end

    assign o_valid = r_valid;
    assign o_rem_s = r_rem_s;
    assign o_den_s = r_den_s;
    assign o_rem_h = r_rem_h;
    assign o_den_h = r_den_h;
    assign o_quot  = r_quot;
    assign o_val   = r_val;
endmodule

/* rtl/rgb_to_hsv_convert.sv */
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts one unsigned RGB pixel to hue, saturation and value per transfer.
// ----------------------------------------------------------------------------
// Pixels enter on i_pix and results leave on o_hsv, both valid/ready channels.
// A transfer on i_pix is one pixel; a transfer on o_hsv is its HSV result.
// The first stage finds the maximum, minimum, chroma and the hue sector.
// A row of sixteen identical divider cells then produces one quotient bit
// of saturation and of hue per cell; each result leaves the last cell on o_hsv.
// One pixel is accepted every cycle while the output is taken, and results
// keep input order. When the receiver stalls, the row keeps moving until
// the last stage is full; then the whole row holds and i_pix.ready falls.
// Bubbles inside the row are not squeezed out.
// Reset is synchronous and active low and empties the row; no other state
// is kept between pixels.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rhc_pix_if.sink   i_pix,
    rhc_hsv_if.source o_hsv
);
    `include "rgb_to_hsv_convert_assert.svh"

    localparam int CB = CHANNEL_BITS;
    localparam int W  = CB + 3;
    localparam int NS = FRAC_BITS;

    logic             v   [NS+1];
    logic [W-1:0]     rs  [NS+1];
    logic [W-1:0]     ds  [NS+1];
    logic [W-1:0]     rh  [NS+1];
    logic [W-1:0]     dh  [NS+1];
    t_quot            q   [NS+1];
    logic [VAL_W-1:0] val [NS+1];

    logic en;
    assign en          = !v[NS] || o_hsv.ready;
    assign i_pix.ready = en;

    logic [CB-1:0]       mx, mn;
    logic [W-1:0]        c, den, num, n_rs, n_ds, n_rh, n_dh;
    logic                n_isat;
    logic [CB+VAL_W-1:0] vx;

    always_comb begin
        mx = i_pix.red;
        mn = i_pix.red;
        if (i_pix.green > mx) mx = i_pix.green;
        if (i_pix.blue  > mx) mx = i_pix.blue;
        if (i_pix.green < mn) mn = i_pix.green;
        if (i_pix.blue  < mn) mn = i_pix.blue;
        c   = W'(mx - mn);
        den = W'(c * W'(6));
        if (mx == i_pix.red) begin
            if (i_pix.green >= i_pix.blue) begin
                num = W'(i_pix.green) - W'(i_pix.blue);
            end else begin
                num = den - (W'(i_pix.blue) - W'(i_pix.green));
            end
        end else if (mx == i_pix.green) begin
            num = W'(c << 1) + W'(i_pix.blue) - W'(i_pix.red);
        end else begin
            num = W'(c << 2) + W'(i_pix.red) - W'(i_pix.green);
        end
        n_isat = (mx != '0) && (c == W'(mx));
        n_rs   = n_isat ? '0 : c;
        n_ds   = (mx == '0) ? '1 : W'(mx);
        n_rh   = (c == '0) ? '0 : num;
        n_dh   = (c == '0) ? '1 : den;
        vx     = {{VAL_W{1'b0}}, mx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            v[0] <= 1'b0;
        end else if (en) begin
            v[0] <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rs[0]    <= n_rs;
            ds[0]    <= n_ds;
            rh[0]    <= n_rh;
            dh[0]    <= n_dh;
            q[0].sat <= {{(SAT_W-1){1'b0}}, n_isat};
            q[0].hue <= '0;
            val[0]   <= vx[VAL_W-1:0];
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_cell
        rhc_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[k]),
            .i_rem_s (rs[k]),
            .i_den_s (ds[k]),
            .i_rem_h (rh[k]),
            .i_den_h (dh[k]),
            .i_quot  (q[k]),
            .i_val   (val[k]),
            .o_valid (v[k+1]),
            .o_rem_s (rs[k+1]),
            .o_den_s (ds[k+1]),
            .o_rem_h (rh[k+1]),
            .o_den_h (dh[k+1]),
            .o_quot  (q[k+1]),
            .o_val   (val[k+1])
        );
    end

    assign o_hsv.valid     = v[NS];
    assign o_hsv.hue_turns = q[NS].hue;
    assign o_hsv.sat_level = q[NS].sat;
    assign o_hsv.val_level = val[NS];

    `RHC_ASSERT_IMPLY(a_sat_full, i_clk, i_rst_n, o_hsv.valid && o_hsv.sat_level[SAT_W-1],
        o_hsv.sat_level[SAT_W-2:0] == '0)
    `RHC_ASSERT_IMPLY(a_rem_below_den, i_clk, i_rst_n, v[NS], rs[NS] < ds[NS] && rh[NS] < dh[NS])
    `RHC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, v[NS] && !o_hsv.ready, v[NS] && $stable(q[NS]))
endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Sends directed and random pixels through the converter with random sender
// gaps and receiver stalls, and checks every HSV result in order against an
// exact integer prediction of hue, saturation and value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import rhc_pkg::*;

    localparam int CB         = 16;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] val;
    } t_hsv;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count = 0;
    int   idle_cycles = 0;
    int   stall_mode = 0;
    t_hsv pending_hsv[$];

    rhc_pix_if #(.CB(CB)) pix_bus ();
    rhc_hsv_if            hsv_bus ();

    rgb_to_hsv_convert #(.CHANNEL_BITS(CB)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus.sink),
        .o_hsv   (hsv_bus.source)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_hsv convert_pixel(logic [CB-1:0] r, logic [CB-1:0] g,
                                           logic [CB-1:0] b);
        logic [63:0] mx;
        logic [63:0] mn;
        logic [63:0] chroma;
        logic [63:0] num;
        t_hsv        res;
        mx = 64'(r);
        mn = 64'(r);
        if (64'(g) > mx) mx = 64'(g);
        if (64'(b) > mx) mx = 64'(b);
        if (64'(g) < mn) mn = 64'(g);
        if (64'(b) < mn) mn = 64'(b);
        chroma = mx - mn;
        res.val = mx[VAL_W-1:0];
        res.sat = '0;
        res.hue = '0;
        if (mx != 0) res.sat = SAT_W'((chroma << FRAC_BITS) / mx);
        if (chroma != 0) begin
            if (mx == 64'(r)) begin
                num = (g >= b) ? (64'(g) - 64'(b)) : (64'(6) * chroma - (64'(b) - 64'(g)));
            end else if (mx == 64'(g)) begin
                num = 64'(2) * chroma + 64'(b) - 64'(r);
            end else begin
                num = 64'(4) * chroma + 64'(r) - 64'(g);
            end
            res.hue = HUE_W'((num << FRAC_BITS) / (64'(6) * chroma));
        end
        return res;
    endfunction

    task automatic send_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
        pix_bus.red   <= r;
        pix_bus.green <= g;
        pix_bus.blue  <= b;
        pix_bus.valid <= 1'b1;
        do @(posedge i_clk); while (!pix_bus.ready);
        pending_hsv.push_back(convert_pixel(r, g, b));
        @(negedge i_clk);
        // Bursts: drop valid only at the end of a burst.
        if ($urandom_range(0, 7) == 0) begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        pix_bus.valid <= 1'b0;
        while (pending_hsv.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_extremes();
        logic [CB-1:0] v[4];
        v = '{16'h0000, 16'h0001, 16'h7FFF, 16'hFFFF};
        foreach (v[i]) send_pixel(v[i], v[i], v[i]);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFE, 16'h0000);
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFE);
        send_pixel(16'hFFFF, 16'h0000, 16'h0001);
        send_pixel(16'h0001, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'h0001, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'h0001);
        send_pixel(16'h1234, 16'h1234, 16'h1233);
        send_pixel(16'h8000, 16'h7FFF, 16'h8000);
        send_pixel(16'hAAAA, 16'h5555, 16'hAAAB);
        drain_results();
    endtask

    task automatic test_random(int count);
        logic [CB-1:0] r;
        logic [CB-1:0] g;
        logic [CB-1:0] b;
        for (int n = 0; n < count; n++) begin
            r = CB'($urandom);
            g = CB'($urandom);
            b = CB'($urandom);
            case ($urandom_range(0, 5))
                0: g = r;
                1: b = r;
                2: b = g;
                3: begin
                    g = r;
                    b = r;
                end
                4: begin
                    r = CB'($urandom_range(0, 3));
                    g = CB'($urandom_range(0, 3));
                    b = CB'($urandom_range(0, 3));
                end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    task automatic test_backpressure();
        stall_mode = 1;
        test_random(300);
        drain_results();
        stall_mode = 2;
        test_random(300);
        stall_mode = 0;
    endtask

    always @(posedge i_clk) begin
        t_hsv exp_hsv;
        if (i_rst_n && hsv_bus.valid && hsv_bus.ready) begin
            if (pending_hsv.size() == 0) begin
                $error("result without pending pixel");
                fail_count++;
            end else begin
                exp_hsv = pending_hsv.pop_front();
                if (hsv_bus.hue_turns !== exp_hsv.hue) begin
                    $error("hue_turns expected %0d actual %0d", exp_hsv.hue,
                           hsv_bus.hue_turns);
                    fail_count++;
                end
                if (hsv_bus.sat_level !== exp_hsv.sat) begin
                    $error("sat_level expected %0d actual %0d", exp_hsv.sat,
                           hsv_bus.sat_level);
                    fail_count++;
                end
                if (hsv_bus.val_level !== exp_hsv.val) begin
                    $error("val_level expected %0d actual %0d", exp_hsv.val,
                           hsv_bus.val_level);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        case (stall_mode)
            0: hsv_bus.ready <= ($urandom_range(0, 3) != 0);
            1: hsv_bus.ready <= 1'b1;
            default: hsv_bus.ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if ((pix_bus.valid && pix_bus.ready) || (hsv_bus.valid && hsv_bus.ready)
                || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        pix_bus.valid = 1'b0;
        pix_bus.red   = '0;
        pix_bus.green = '0;
        pix_bus.blue  = '0;
        hsv_bus.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_extremes();
        test_random(1200);
        test_backpressure();
        drain_results();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending_hsv.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
